/* rtl/core/ascii_frame_receiver_checksum_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ASCII frame receiver
// Clocked assertion helpers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASCII_FRAME_RECEIVER_CHECKSUM_MACROS_SVH
`define ASCII_FRAME_RECEIVER_CHECKSUM_MACROS_SVH

`ifndef ASSERT_OFF
// Implication or plain property, checked out of reset.
`define AFRC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Condition that must never be true, checked out of reset.
`define AFRC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);
`else
`define AFRC_ASSERT(label, clk, rst_n, prop, msg)
`define AFRC_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

/* rtl/core/afrc_pkg.sv */
// ----------------------------------------------------------------------------
// ASCII frame receiver package
// Shared constants, result type and hex digit helper.
// ----------------------------------------------------------------------------
package afrc_pkg;

    localparam int unsigned MAX_FRAME = 64;

    localparam logic [7:0] START_CHAR  = 8'h40;
    localparam logic [7:0] END_CHAR    = 8'h23;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    localparam logic [6:0] LEN_RESET = 7'd28;
    localparam logic [6:0] LEN_MIN   = 7'd9;
    // byte_position reaches 63 at most, so the length never exceeds 64.
    localparam logic [6:0] LEN_MAX   = (MAX_FRAME > 64) ? 7'd64 : 7'(MAX_FRAME);

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM     = 2'd1;
    localparam logic [1:0] STATUS_EARLY_END   = 2'd2;
    localparam logic [1:0] STATUS_MISSING_END = 2'd3;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [5:0] byte_position;
        logic       frame_end;
        logic [1:0] frame_status;
    } result_t;

    // Upper-case ASCII hex digit of one nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
        logic [3:0] n;
        n = nibble & NIBBLE_MASK;
        if (n < 4'd10) begin
            return 8'h30 + {4'd0, n};
        end
        return 8'h41 + {4'd0, n - 4'd10};
    endfunction

endpackage

/* rtl/core/afrc_input_stage.sv */
// ----------------------------------------------------------------------------
// Input register
// Holds one received byte until the frame checker consumes it.
// ----------------------------------------------------------------------------
module afrc_input_stage
    import afrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The register may refill in the same cycle it is consumed.
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

/* rtl/core/afrc_frame_checker.sv */
// ----------------------------------------------------------------------------
// Frame checker
// Frame state, running checksum and the per-byte decision.
// ----------------------------------------------------------------------------
`include "ascii_frame_receiver_checksum_macros.svh"

module afrc_frame_checker
    import afrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    input  logic [6:0] cfg_frame_size,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output logic       emit,
    output result_t    result
);

    logic [6:0] length_reg;
    logic       in_frame_reg;
    logic       in_frame_next;
    logic [5:0] position_reg;
    logic [5:0] position_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic       high_ok_reg;
    logic       high_ok_next;
    logic       low_ok_reg;
    logic       low_ok_next;

    logic [6:0] len_eff;
    logic [5:0] pos_inc;
    logic [6:0] pos_wide;

    always_comb begin
        if (length_reg < LEN_MIN) begin
            len_eff = LEN_MIN;
        end else if (length_reg > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = length_reg;
        end
    end

    assign pos_inc  = position_reg + 6'd1;
    assign pos_wide = {1'b0, pos_inc};

    always_comb begin
        in_frame_next = in_frame_reg;
        position_next = position_reg;
        sum_next      = sum_reg;
        high_ok_next  = high_ok_reg;
        low_ok_next   = low_ok_reg;
        emit          = 1'b0;
        result        = '{frame_byte: rx_byte, byte_position: pos_inc,
                          frame_end: 1'b0, frame_status: STATUS_OK};
        if (!in_frame_reg) begin
            result.byte_position = 6'd0;
            if (rx_byte == START_CHAR) begin
                emit          = 1'b1;
                in_frame_next = 1'b1;
                position_next = 6'd0;
                sum_next      = 8'd0;
                high_ok_next  = 1'b0;
                low_ok_next   = 1'b0;
            end
        end else begin
            emit = 1'b1;
            if (pos_wide >= len_eff - 7'd1) begin
                result.frame_end = 1'b1;
                if (rx_byte != END_CHAR) begin
                    result.frame_status = STATUS_MISSING_END;
                end else if (!(high_ok_reg && low_ok_reg)) begin
                    result.frame_status = STATUS_BAD_SUM;
                end
            end else if (rx_byte == END_CHAR) begin
                result.frame_end    = 1'b1;
                result.frame_status = STATUS_EARLY_END;
            end else begin
                position_next = pos_inc;
                if (pos_wide <= len_eff - 7'd4) begin
                    sum_next = sum_reg + rx_byte;
                end
                if (pos_wide == len_eff - 7'd3) begin
                    high_ok_next = (rx_byte == hex_digit(sum_reg[7:4]));
                end
                if (pos_wide == len_eff - 7'd2) begin
                    low_ok_next = (rx_byte == hex_digit(sum_reg[3:0]));
                end
            end
            if (result.frame_end) begin
                in_frame_next = 1'b0;
                position_next = 6'd0;
                sum_next      = 8'd0;
                high_ok_next  = 1'b0;
                low_ok_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg   <= LEN_RESET;
            in_frame_reg <= 1'b0;
            position_reg <= 6'd0;
            sum_reg      <= 8'd0;
            high_ok_reg  <= 1'b0;
            low_ok_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                length_reg <= cfg_frame_size;
            end
            if (step) begin
                in_frame_reg <= in_frame_next;
                position_reg <= position_next;
                sum_reg      <= sum_next;
                high_ok_reg  <= high_ok_next;
                low_ok_reg   <= low_ok_next;
            end
        end
    end

    `AFRC_ASSERT_NEVER(a_status_only_at_end, aclk, aresetn, emit && !result.frame_end && (result.frame_status != STATUS_OK), "status set on a byte that does not end a frame")
    `AFRC_ASSERT(a_start_at_zero, aclk, aresetn, (emit && !in_frame_reg) |-> (result.byte_position == 6'd0 && result.frame_byte == START_CHAR), "frame start not at position zero")
    `AFRC_ASSERT(a_end_goes_idle, aclk, aresetn, (step && emit && result.frame_end) |=> !in_frame_reg, "frame did not close after its last byte")
    `AFRC_ASSERT(a_idle_at_zero, aclk, aresetn, !in_frame_reg |-> (position_reg == 6'd0), "position not cleared while idle")

endmodule

/* rtl/core/afrc_output_stage.sv */
// ----------------------------------------------------------------------------
// Result register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module afrc_output_stage
    import afrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  result_t    load_data,
    output logic       space,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_frame_byte,
    output logic [5:0] m_byte_position,
    output logic       m_frame_end,
    output logic [1:0] m_frame_status
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign space      = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid         = valid_reg;
    assign m_frame_byte    = data_reg.frame_byte;
    assign m_byte_position = data_reg.byte_position;
    assign m_frame_end     = data_reg.frame_end;
    assign m_frame_status  = data_reg.frame_status;

endmodule

/* rtl/core/ascii_frame_receiver_checksum.sv */
// ----------------------------------------------------------------------------
// ASCII frame receiver with hex checksum check
// Frames '@' ... '#' byte streams and checks a two-digit hex sum.
// ----------------------------------------------------------------------------
// The block accepts one received byte per clock while m_ready does not
// stall the result register, and produces at most one result beat per byte.
// Each byte passes an input register, combinational frame checking logic
// and a result register; the frame state is updated as the byte moves from
// the input register into the result register. A byte waits in the input
// register while the result register holds a beat that is not taken. While
// idle, bytes other than '@' are dropped without a
// result. A frame runs for the configured number of bytes (clamped to
// 9..64); its last beat carries frame_end and a status: ok, checksum
// mismatch, early end ('#' before the last position) or missing end (no '#'
// at the last position). The checksum is the mod-256 sum of positions 1 to
// length-4, sent as two upper-case hex digits at length-3 and length-2.
// The frame size register resets to 28 and should only be written while
// no beats are in flight; cfg_ready is always high.
// ----------------------------------------------------------------------------
module ascii_frame_receiver_checksum
    import afrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] cfg_frame_size,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_frame_byte,
    output logic [5:0] m_byte_position,
    output logic       m_frame_end,
    output logic [1:0] m_frame_status
);

    logic       held_valid;
    logic [7:0] held_byte;
    logic       out_space;
    logic       step;
    logic       emit;
    result_t    result;

    // The configuration register is a plain write, always accepted.
    assign cfg_ready = 1'b1;

    // A held byte is consumed whenever the result register can take a beat;
    // dropped idle bytes are consumed the same way and produce nothing.
    assign step = held_valid && out_space;

    afrc_input_stage u_input (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .take       (step),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    afrc_frame_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_frame_size (cfg_frame_size),
        .step           (step),
        .rx_byte        (held_byte),
        .emit           (emit),
        .result         (result)
    );

    afrc_output_stage u_output (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (step && emit),
        .load_data       (result),
        .space           (out_space),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_byte    (m_frame_byte),
        .m_byte_position (m_byte_position),
        .m_frame_end     (m_frame_end),
        .m_frame_status  (m_frame_status)
    );

endmodule
